@@ hdl/elg_pkg.sv @@
// Package for the ElGamal engine: payload structs, register indexes,
// datapath command and status types. No dependencies.
package elg_pkg;

  localparam int unsigned ModulusBits = 31;
  localparam int unsigned CfgIdxBits  = 2;

  localparam logic [CfgIdxBits-1:0] RegModulus    = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegGenerator  = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegPrivateKey = 2'd2;

  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  typedef struct packed {
    logic                   operation;
    logic [ModulusBits-1:0] plaintext;
    logic [ModulusBits-1:0] ephemeral_key;
    logic [ModulusBits-1:0] cipher_first;
    logic [ModulusBits-1:0] cipher_second;
  } req_t;

  typedef struct packed {
    logic [ModulusBits-1:0] result_first;
    logic [ModulusBits-1:0] result_second;
    logic                   status;
  } rsp_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DpNop,
    DpLoad,      // latch item, start operand reduction
    DpRedStep,   // one step of operand reduction
    DpMulStart,  // start a modular multiply, operands by select
    DpMulStep,   // one bit of the modular multiply
    DpDivStart,  // start one Euclid division
    DpDivStep,   // one bit of the division
    DpEuclidUpd  // move remainders and coefficients on
  } dp_cmd_e;

  // Multiply operand/destination selects.
  typedef enum logic [2:0] {
    MulRxB,      // acc := acc * base
    MulBxB,      // base := base * base
    MulQxT,      // tmp := q * t_cur
    MulAxB2,     // fin := msg * acc, or c2 * t_old on decrypt (final product)
    MulNone
  } mul_sel_e;

  // Base of an exponentiation.
  typedef enum logic [1:0] {
    PowGen,
    PowPub,
    PowC1
  } pow_src_e;

  // Kind of result handed to the output.
  typedef enum logic [1:0] {
    KindOk,
    KindZero,
    KindNoInv
  } res_kind_e;

  typedef struct packed {
    dp_cmd_e  cmd;
    mul_sel_e sel;
    pow_src_e pow_src;
    logic     pow_exp;  // 0 private key, 1 ephemeral key
  } dp_ctl_t;

  typedef struct packed {
    logic red_done;
    logic mul_done;
    logic div_done;
    logic rcur_zero;
    logic rold_one;
    logic exp_bit;
    logic exp_zero;
    logic op;
    logic p_small;
  } dp_sts_t;

endpackage

@@ hdl/elgamal_encrypt_decrypt.sv @@
// Top level of the ElGamal engine: configuration registers, controller and
// datapath, result register. Uses elg_pkg, elg_ctrl, elg_datapath.
//
//   channel  signals                          direction
//   cfg      cfg_valid_i cfg_ready_o cfg_*    write, valid/ready
//   req      start_i busy_o req_i             in, taken when start & !busy
//   rsp      done_o rsp_o                     out, one-cycle strobe
//
// An item runs operand reduction, then per exponentiation (three on
// encrypt, one on decrypt) a squaring per exponent bit and a multiply more
// per set bit, then on decrypt the Euclid steps of the inversion, then
// the final product and a finishing state. The multiplier and divider
// are bit-serial. Reset is asynchronous and loads
// modulus 3, generator 2, private key 1. The receiver cannot stall; done_o is
// high for one cycle with rsp_o valid.
module elgamal_encrypt_decrypt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [elg_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [elg_pkg::ModulusBits-1:0] cfg_data_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  elg_pkg::req_t                   req_i,
  output logic                            done_o,
  output elg_pkg::rsp_t                   rsp_o
);

  localparam int unsigned W = elg_pkg::ModulusBits;

  logic [W-1:0] modulus_q, generator_q, private_key_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= W'(3); generator_q <= W'(2); private_key_q <= W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        elg_pkg::RegModulus:    modulus_q     <= cfg_data_i;
        elg_pkg::RegGenerator:  generator_q   <= cfg_data_i;
        elg_pkg::RegPrivateKey: private_key_q <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign cfg_ready_o = 1'b1;

  elg_pkg::dp_ctl_t ctl;
  elg_pkg::dp_sts_t sts;
  logic pow_init, exp_shift, pub_save, r1_save, inv_init, done;
  elg_pkg::res_kind_e kind;
  logic [W-1:0] res1, res2;

  elg_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o, .sts_i(sts), .ctl_o(ctl),
    .pow_init_o(pow_init), .exp_shift_o(exp_shift), .pub_save_o(pub_save),
    .r1_save_o(r1_save), .inv_init_o(inv_init), .done_o(done), .res_kind_o(kind)
  );

  elg_datapath #(.W(W)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl),
    .modulus_i(modulus_q), .generator_i(generator_q), .private_key_i(private_key_q),
    .op_i(req_i.operation), .msg_i(req_i.plaintext), .eph_i(req_i.ephemeral_key),
    .c1_i(req_i.cipher_first), .c2_i(req_i.cipher_second),
    .pow_init_i(pow_init), .exp_shift_i(exp_shift), .pub_save_i(pub_save),
    .r1_save_i(r1_save), .inv_init_i(inv_init), .sts_o(sts), .res1_o(res1), .res2_o(res2)
  );

  always_comb begin
    rsp_o = '0;
    if (kind == elg_pkg::KindOk) begin
      if (sts.op) begin
        rsp_o.result_first = res2;
      end else begin
        rsp_o.result_first  = res1;
        rsp_o.result_second = res2;
      end
    end else if (kind == elg_pkg::KindNoInv) begin
      rsp_o.status = 1'b1;
    end
  end
  assign done_o = done;

endmodule

@@ hdl/elg_datapath.sv @@
// Datapath of the ElGamal engine: operand reduction, bit-serial modular
// multiply, exponent shifter and bit-serial Euclid divider. Uses elg_pkg.
module elg_datapath #(
  parameter int unsigned W = elg_pkg::ModulusBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  elg_pkg::dp_ctl_t    ctl_i,
  input  logic [W-1:0]        modulus_i,
  input  logic [W-1:0]        generator_i,
  input  logic [W-1:0]        private_key_i,
  input  logic                op_i,
  input  logic [W-1:0]        msg_i,
  input  logic [W-1:0]        eph_i,
  input  logic [W-1:0]        c1_i,
  input  logic [W-1:0]        c2_i,
  input  logic                pow_init_i,
  input  logic                exp_shift_i,
  input  logic                pub_save_i,
  input  logic                r1_save_i,
  input  logic                inv_init_i,
  output elg_pkg::dp_sts_t    sts_o,
  output logic [W-1:0]        res1_o,
  output logic [W-1:0]        res2_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0] p_q, gen_q, msg_q, c1_q, c2_q, eph_q, key_q;
  logic         op_q;
  logic [CW-1:0] red_cnt_q, red_cnt_d;
  logic [1:0]   red_idx_q, red_idx_d;

  logic [W-1:0] acc_q, acc_d, base_q, base_d, exp_q, exp_d, pub_q, pub_d, r1_q, r1_d;
  logic [W-1:0] ma_q, mb_q, mr_q, mr_d, fin_q, fin_d, tmp_q, tmp_d;
  logic [CW-1:0] mcnt_q, mcnt_d;
  logic [2:0]   mdst_q, mdst_d;

  logic [W-1:0] rold_q, rold_d, rcur_q, rcur_d, told_q, told_d, tcur_q, tcur_d;
  logic [W-1:0] quo_q, quo_d, rem_q, rem_d, dvd_q, dvd_d;
  logic [CW-1:0] dcnt_q, dcnt_d;

  // Reduction target selected by index: 0 gen, 1 msg, 2 c1, 3 c2.
  logic [W-1:0] red_val;
  always_comb begin
    unique case (red_idx_q)
      2'd0: red_val = gen_q;
      2'd1: red_val = msg_q;
      2'd2: red_val = c1_q;
      default: red_val = c2_q;
    endcase
  end

  // Modular doubling and addition, operands below p.
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] m);
    logic [W-1:0] mb;
    begin
      mb = m - b;
      add_mod = (a >= mb) ? a - mb : a + b;
    end
  endfunction

  logic [W-1:0] mr_dbl, mr_add;
  assign mr_dbl = add_mod(mr_q, mr_q, p_q);
  assign mr_add = mb_q[W-1] ? add_mod(mr_dbl, ma_q, p_q) : mr_dbl;

  // Division: restoring, one quotient bit a step.
  logic [W:0] rem_sh;
  assign rem_sh = {rem_q, dvd_q[W-1]};

  logic [W-1:0] sub_t;
  assign sub_t = (told_q >= tmp_q) ? told_q - tmp_q : told_q + (p_q - tmp_q);

  always_comb begin
    red_cnt_d = red_cnt_q; red_idx_d = red_idx_q;
    acc_d = acc_q; base_d = base_q; exp_d = exp_q; pub_d = pub_q; r1_d = r1_q;
    mr_d = mr_q; fin_d = fin_q; tmp_d = tmp_q; mcnt_d = mcnt_q; mdst_d = mdst_q;
    rold_d = rold_q; rcur_d = rcur_q; told_d = told_q; tcur_d = tcur_q;
    quo_d = quo_q; rem_d = rem_q; dvd_d = dvd_q; dcnt_d = dcnt_q;
    if (pow_init_i) begin
      acc_d  = {{(W-1){1'b0}}, 1'b1};
      unique case (ctl_i.pow_src)
        elg_pkg::PowGen: base_d = gen_q;
        elg_pkg::PowPub: base_d = pub_q;
        default: base_d = c1_q;
      endcase
      exp_d = ctl_i.pow_exp ? eph_q : key_q;
    end
    if (exp_shift_i) exp_d = exp_q >> 1;
    if (pub_save_i) pub_d = acc_q;
    if (r1_save_i) r1_d = acc_q;
    if (inv_init_i) begin
      rold_d = p_q; rcur_d = acc_q; told_d = '0; tcur_d = {{(W-1){1'b0}}, 1'b1};
    end
    unique case (ctl_i.cmd)
      elg_pkg::DpLoad: begin
        red_cnt_d = '0; red_idx_d = '0;
      end
      elg_pkg::DpRedStep: begin
        // Subtract p while value >= p; at most 2^W/p steps is too many, so
        // reduce by shifted p: one bit position a step, MSB first.
        red_cnt_d = red_cnt_q + 1'b1;
        if (red_cnt_q == CW'(W)) begin
          red_cnt_d = '0;
          red_idx_d = red_idx_q + 1'b1;
        end
      end
      elg_pkg::DpMulStart: begin
        mr_d = '0; mcnt_d = '0; mdst_d = ctl_i.sel;
      end
      elg_pkg::DpMulStep: begin
        mr_d = mr_add; mcnt_d = mcnt_q + 1'b1;
        if (mcnt_q == CW'(W - 1)) begin
          unique case (mdst_q)
            3'(elg_pkg::MulRxB):  acc_d  = mr_add;
            3'(elg_pkg::MulBxB):  base_d = mr_add;
            3'(elg_pkg::MulQxT):  tmp_d  = mr_add;
            default:              fin_d  = mr_add;
          endcase
        end
      end
      elg_pkg::DpDivStart: begin
        rem_d = '0; quo_d = '0; dvd_d = rold_q; dcnt_d = '0;
      end
      elg_pkg::DpDivStep: begin
        dcnt_d = dcnt_q + 1'b1;
        dvd_d  = dvd_q << 1;
        if (rem_sh >= {1'b0, rcur_q}) begin
          rem_d = W'(rem_sh - {1'b0, rcur_q});
          quo_d = {quo_q[W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b0};
        end
      end
      elg_pkg::DpEuclidUpd: begin
        rold_d = rcur_q; rcur_d = rem_q; told_d = tcur_q; tcur_d = sub_t;
      end
      default: ;
    endcase
  end

  // Reduction step: conditional subtract of p shifted by (W - cnt).
  logic [2*W-1:0] p_shift;
  logic [W-1:0]   red_next;
  always_comb begin
    p_shift  = {{W{1'b0}}, p_q} << (CW'(W) - red_cnt_q);
    red_next = red_val;
    if (red_cnt_q <= CW'(W) && {{W{1'b0}}, red_val} >= p_shift) red_next = W'(red_val - p_shift[W-1:0]);
  end

  logic [W-1:0] ma_sel, mb_sel;
  always_comb begin
    unique case (ctl_i.sel)
      elg_pkg::MulRxB:  begin ma_sel = acc_q;  mb_sel = base_q; end
      elg_pkg::MulBxB:  begin ma_sel = base_q; mb_sel = base_q; end
      elg_pkg::MulQxT:  begin ma_sel = tcur_q; mb_sel = quo_q;  end
      elg_pkg::MulAxB2: begin ma_sel = op_q ? c2_q : msg_q; mb_sel = op_q ? told_q : acc_q; end
      default:          begin ma_sel = '0;     mb_sel = '0;     end
    endcase
  end

  // q <= p here: quotient of r_old by r_cur <= p < 2^W, and q<p unless r_cur=1
  // with r_old=p, whose t product is then unused.
  logic [W-1:0] q_red;
  assign q_red = (quo_q >= p_q) ? quo_q - p_q : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_cnt_q <= '0; red_idx_q <= '0; mcnt_q <= '0; dcnt_q <= '0; mdst_q <= '0;
    end else begin
      red_cnt_q <= red_cnt_d; red_idx_q <= red_idx_d; mcnt_q <= mcnt_d;
      dcnt_q <= dcnt_d; mdst_q <= mdst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; base_q <= base_d; exp_q <= exp_d; pub_q <= pub_d; r1_q <= r1_d;
    mr_q <= mr_d; fin_q <= fin_d; tmp_q <= tmp_d;
    rold_q <= rold_d; rcur_q <= rcur_d; told_q <= told_d; tcur_q <= tcur_d;
    quo_q <= quo_d; rem_q <= rem_d; dvd_q <= dvd_d;
    if (ctl_i.cmd == elg_pkg::DpMulStart) begin
      ma_q <= ma_sel;
      mb_q <= (ctl_i.sel == elg_pkg::MulQxT) ? q_red : mb_sel;
    end else if (ctl_i.cmd == elg_pkg::DpMulStep) begin
      mb_q <= mb_q << 1;
    end
    if (ctl_i.cmd == elg_pkg::DpLoad) begin
      p_q <= modulus_i; gen_q <= generator_i; key_q <= private_key_i; op_q <= op_i;
      msg_q <= msg_i; eph_q <= eph_i; c1_q <= c1_i; c2_q <= c2_i;
    end else if (ctl_i.cmd == elg_pkg::DpRedStep) begin
      unique case (red_idx_q)
        2'd0: gen_q <= red_next;
        2'd1: msg_q <= red_next;
        2'd2: c1_q  <= red_next;
        default: c2_q <= red_next;
      endcase
    end
  end

  assign sts_o.red_done  = (ctl_i.cmd == elg_pkg::DpRedStep) && red_idx_q == 2'd3 &&
                           red_cnt_q == CW'(W);
  assign sts_o.mul_done  = (mcnt_q == CW'(W - 1));
  assign sts_o.div_done  = (dcnt_q == CW'(W - 1));
  assign sts_o.rcur_zero = (rcur_q == '0);
  assign sts_o.rold_one  = (rold_q == {{(W-1){1'b0}}, 1'b1});
  assign sts_o.exp_bit   = exp_q[0];
  assign sts_o.exp_zero  = (exp_q == '0);
  assign sts_o.op        = op_q;
  assign sts_o.p_small   = (p_q[W-1:1] == '0);
  assign res1_o = r1_q;
  assign res2_o = fin_q;

endmodule

@@ hdl/elg_ctrl.sv @@
// Controller of the ElGamal engine: sequences reduction, exponentiations,
// inversion and the final product on the datapath. Uses elg_pkg.
module elg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  elg_pkg::dp_sts_t   sts_i,
  output elg_pkg::dp_ctl_t   ctl_o,
  output logic               pow_init_o,
  output logic               exp_shift_o,
  output logic               pub_save_o,
  output logic               r1_save_o,
  output logic               inv_init_o,
  output logic               done_o,
  output elg_pkg::res_kind_e res_kind_o
);

  typedef enum logic [3:0] {
    StIdle, StReduce, StPowInit, StPowTest, StPowMulR, StPowMulB, StPowDone,
    StInvTest, StDiv, StDivMul, StUpd, StFinMul, StDone
  } state_e;

  // Exponentiation phases.
  localparam logic [1:0] PhPub = 2'd0, PhC1 = 2'd1, PhShared = 2'd2, PhDec = 2'd3;

  state_e             state_q;
  logic [1:0]         ph_q;
  logic               mul_run_q;
  elg_pkg::res_kind_e kind_q;

  elg_pkg::dp_ctl_t c;
  always_comb begin
    c.cmd = elg_pkg::DpNop; c.sel = elg_pkg::MulNone; c.pow_src = elg_pkg::PowGen;
    c.pow_exp = 1'b0;
    pow_init_o = 1'b0; exp_shift_o = 1'b0; pub_save_o = 1'b0; r1_save_o = 1'b0;
    inv_init_o = 1'b0;
    unique case (state_q)
      StIdle:   if (start_i) c.cmd = elg_pkg::DpLoad;
      StReduce: c.cmd = elg_pkg::DpRedStep;
      StPowInit: begin
        pow_init_o = 1'b1;
        unique case (ph_q)
          PhPub:    begin c.pow_src = elg_pkg::PowGen; c.pow_exp = 1'b0; end
          PhC1:     begin c.pow_src = elg_pkg::PowGen; c.pow_exp = 1'b1; end
          PhShared: begin c.pow_src = elg_pkg::PowPub; c.pow_exp = 1'b1; end
          default:  begin c.pow_src = elg_pkg::PowC1;  c.pow_exp = 1'b0; end
        endcase
      end
      StPowMulR: begin
        c.sel = elg_pkg::MulRxB;
        c.cmd = mul_run_q ? elg_pkg::DpMulStep : elg_pkg::DpMulStart;
      end
      StPowMulB: begin
        c.sel = elg_pkg::MulBxB;
        c.cmd = mul_run_q ? elg_pkg::DpMulStep : elg_pkg::DpMulStart;
        if (mul_run_q && sts_i.mul_done) exp_shift_o = 1'b1;
      end
      StPowDone: begin
        pub_save_o = (ph_q == PhPub);
        r1_save_o  = (ph_q == PhC1);
        inv_init_o = (ph_q == PhDec);
      end
      StDiv: c.cmd = mul_run_q ? elg_pkg::DpDivStep : elg_pkg::DpDivStart;
      StDivMul: begin
        c.sel = elg_pkg::MulQxT;
        c.cmd = mul_run_q ? elg_pkg::DpMulStep : elg_pkg::DpMulStart;
      end
      StUpd: c.cmd = elg_pkg::DpEuclidUpd;
      StFinMul: begin
        c.sel = elg_pkg::MulAxB2;
        c.cmd = mul_run_q ? elg_pkg::DpMulStep : elg_pkg::DpMulStart;
      end
      default: ;
    endcase
  end
  assign ctl_o = c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ph_q <= PhPub; mul_run_q <= 1'b0; kind_q <= elg_pkg::KindOk;
      done_o <= 1'b0;
    end else begin
      done_o <= (state_q == StDone);
      unique case (state_q)
        StIdle: if (start_i) state_q <= StReduce;
        StReduce: if (sts_i.red_done) begin
          if (sts_i.p_small) begin
            kind_q <= sts_i.op ? elg_pkg::KindNoInv : elg_pkg::KindZero;
            state_q <= StDone;
          end else begin
            kind_q <= elg_pkg::KindOk;
            ph_q <= sts_i.op ? PhDec : PhPub;
            state_q <= StPowInit;
          end
        end
        StPowInit: state_q <= StPowTest;
        StPowTest: state_q <= sts_i.exp_zero ? StPowDone :
                              (sts_i.exp_bit ? StPowMulR : StPowMulB);
        StPowMulR: begin
          if (mul_run_q && sts_i.mul_done) begin
            mul_run_q <= 1'b0; state_q <= StPowMulB;
          end else mul_run_q <= 1'b1;
        end
        StPowMulB: begin
          if (mul_run_q && sts_i.mul_done) begin
            mul_run_q <= 1'b0; state_q <= StPowTest;
          end else mul_run_q <= 1'b1;
        end
        StPowDone: begin
          unique case (ph_q)
            PhPub:    begin ph_q <= PhC1; state_q <= StPowInit; end
            PhC1:     begin ph_q <= PhShared; state_q <= StPowInit; end
            PhShared: state_q <= StFinMul;
            default:  state_q <= StInvTest;
          endcase
        end
        StInvTest: begin
          if (sts_i.rcur_zero) begin
            if (sts_i.rold_one) state_q <= StFinMul;
            else begin kind_q <= elg_pkg::KindNoInv; state_q <= StDone; end
          end else state_q <= StDiv;
        end
        StDiv: begin
          if (mul_run_q && sts_i.div_done) begin
            mul_run_q <= 1'b0; state_q <= StDivMul;
          end else mul_run_q <= 1'b1;
        end
        StDivMul: begin
          if (mul_run_q && sts_i.mul_done) begin
            mul_run_q <= 1'b0; state_q <= StUpd;
          end else mul_run_q <= 1'b1;
        end
        StUpd: state_q <= StInvTest;
        StFinMul: begin
          if (mul_run_q && sts_i.mul_done) begin
            mul_run_q <= 1'b0; state_q <= StDone;
          end else mul_run_q <= 1'b1;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle);
  assign res_kind_o = kind_q;

endmodule
